/* rtl/ppil_pkg.sv */
`default_nettype none
package ppil_pkg;
    localparam int CW = 24;
    localparam int PW = 2 * CW;
    localparam int DW = 2 * CW + 1;
    localparam int FRAC = 2 * (CW / 2);
    localparam int QW = PW + FRAC;
    localparam int NSTEP = QW;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [DW-1:0] dx;
        logic [DW-1:0] dy;
        logic [DW-1:0] dz;
        logic          found;
        logic [1:0]    axis;
        logic [PW-1:0] den;
        logic [PW-1:0] num_u;
        logic          neg_u;
        logic          zero_u;
        logic [PW-1:0] num_v;
        logic          neg_v;
        logic          zero_v;
    } ppil_ctx_t;

    typedef struct packed {
        logic [QW-1:0] rem;
        logic [QW-1:0] q;
    } ppil_div_t;
endpackage
`default_nettype wire

/* rtl/plane_pair_intersection_line_unit.sv */
`default_nettype none
// Line of intersection of two planes, one plane pair per beat.
// Input channel: in_valid/in_ready with the eight Q12.12 coefficients.
// Config channel: cfg_valid/cfg_ready writes det_epsilon (always ready);
// write it only while the unit is empty.
// Output channel: out_valid/out_ready with direction, point and flags.
// The front end takes two registered stages (products, then determinants and
// selection); then a chain of QW = 72 division cells, one quotient bit per
// cell, works both point coordinates; a last stage saturates and signs.
// One beat is accepted every cycle while the output is taken.
// The pipeline advances as a whole: when out_valid is high and out_ready is
// low, every stage holds and in_ready falls, so no beat is lost.
// Reset empties the pipeline and sets det_epsilon to 17.
module plane_pair_intersection_line_unit
    import ppil_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [CW-1:0] first_a,
    input  wire logic signed [CW-1:0] first_b,
    input  wire logic signed [CW-1:0] first_c,
    input  wire logic signed [CW-1:0] first_d,
    input  wire logic signed [CW-1:0] second_a,
    input  wire logic signed [CW-1:0] second_b,
    input  wire logic signed [CW-1:0] second_c,
    input  wire logic signed [CW-1:0] second_d,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [PW-1:0]        det_epsilon,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [DW-1:0]      dir_x,
    output logic signed [DW-1:0]      dir_y,
    output logic signed [DW-1:0]      dir_z,
    output logic signed [PW-1:0]      point_x,
    output logic signed [PW-1:0]      point_y,
    output logic signed [PW-1:0]      point_z,
    output logic                      found,
    output logic [1:0]                zero_axis,
    output logic                      clipped
);
    logic en;
    logic [PW-1:0] eps_reg;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= PW'(17);
        else if (cfg_valid)
            eps_reg <= det_epsilon;
    end

    // Stage 1: the fourteen products.
    logic signed [PW-1:0] b1c2_reg, b2c1_reg, a1c2_reg, a2c1_reg, a1b2_reg, a2b1_reg;
    logic signed [PW-1:0] d2c1_reg, d1c2_reg, b2d1_reg, b1d2_reg, a2d1_reg, a1d2_reg;
    logic signed [PW-1:0] d2b1_reg, d1b2_reg;
    logic v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1c2_reg <= first_b * second_c;
            b2c1_reg <= second_b * first_c;
            a1c2_reg <= first_a * second_c;
            a2c1_reg <= second_a * first_c;
            a1b2_reg <= first_a * second_b;
            a2b1_reg <= second_a * first_b;
            d2c1_reg <= second_d * first_c;
            d1c2_reg <= first_d * second_c;
            b2d1_reg <= second_b * first_d;
            b1d2_reg <= first_b * second_d;
            a2d1_reg <= second_a * first_d;
            a1d2_reg <= first_a * second_d;
            d2b1_reg <= second_d * first_b;
            d1b2_reg <= first_d * second_b;
        end
    end

    // Stage 2: determinants, selection, magnitudes.
    logic signed [DW-1:0] det_yz, det_xz, det_xy, dir_y_c;
    logic signed [DW-1:0] n_cz, n_bz, n_az, n_bx;
    logic use_yz, use_xz, use_xy;
    logic signed [DW-1:0] sel_det, sel_u, sel_v;
    ppil_ctx_t c2_next;

    function automatic logic [DW-1:0] mag(logic signed [DW-1:0] x);
        return x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

    always_comb
    begin
        det_yz  = DW'(b1c2_reg) - DW'(b2c1_reg);
        det_xz  = DW'(a1c2_reg) - DW'(a2c1_reg);
        det_xy  = DW'(a1b2_reg) - DW'(a2b1_reg);
        dir_y_c = DW'(a2c1_reg) - DW'(a1c2_reg);
        n_cz    = DW'(d2c1_reg) - DW'(d1c2_reg);
        n_bz    = DW'(b2d1_reg) - DW'(b1d2_reg);
        n_az    = DW'(a2d1_reg) - DW'(a1d2_reg);
        n_bx    = DW'(d2b1_reg) - DW'(d1b2_reg);
        use_yz  = det_yz != '0 && mag(det_yz) >= {1'b0, eps_reg};
        use_xz  = det_xz != '0 && mag(det_xz) >= {1'b0, eps_reg};
        use_xy  = det_xy != '0 && mag(det_xy) >= {1'b0, eps_reg};
        c2_next = '0;
        sel_det = det_xy;
        sel_u   = n_bx;
        sel_v   = n_az;
        c2_next.axis = AXIS_Z;
        if (use_yz)
        begin
            sel_det = det_yz;
            sel_u   = n_cz;
            sel_v   = n_bz;
            c2_next.axis = AXIS_X;
        end
        else if (use_xz)
        begin
            sel_det = det_xz;
            sel_u   = n_cz;
            sel_v   = n_az;
            c2_next.axis = AXIS_Y;
        end
        c2_next.found = use_yz || use_xz || use_xy;
        if (!c2_next.found)
            c2_next.axis = AXIS_X;
        c2_next.dx = det_yz;
        c2_next.dy = dir_y_c;
        c2_next.dz = det_xy;
        // Magnitudes stay below 2^(PW-1)+1, so PW bits hold them.
        c2_next.den    = PW'(mag(sel_det));
        c2_next.num_u  = PW'(mag(sel_u));
        c2_next.neg_u  = sel_u[DW-1] ^ sel_det[DW-1];
        c2_next.zero_u = sel_u == '0;
        c2_next.num_v  = PW'(mag(sel_v));
        c2_next.neg_v  = sel_v[DW-1] ^ sel_det[DW-1];
        c2_next.zero_v = sel_v == '0;
    end

    ppil_ctx_t c2_reg;
    logic v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c2_reg <= c2_next;
    end

    // Division chain.
    logic      vch [NSTEP+1];
    ppil_ctx_t cch [NSTEP+1];
    ppil_div_t uch [NSTEP+1];
    ppil_div_t wch [NSTEP+1];

    assign vch[0] = v2_reg;
    assign cch[0] = c2_reg;
    assign uch[0] = '0;
    assign wch[0] = '0;

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cell
        ppil_cell #(.STEP(i)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (vch[i]),
            .cin  (cch[i]),
            .uin  (uch[i]),
            .win  (wch[i]),
            .vout (vch[i+1]),
            .cout (cch[i+1]),
            .uout (uch[i+1]),
            .wout (wch[i+1])
        );
    end

    // Final stage: sign and saturate.
    localparam logic [QW-1:0] LIM = QW'(1) << (PW - 1);

    function automatic logic [PW:0] fin(logic [QW-1:0] q, logic neg, logic zero);
        logic [PW-1:0] r;
        logic          c;
        c = 1'b0;
        if (zero)
            r = '0;
        else if (neg)
        begin
            if (q > LIM)
            begin
                r = PW'(LIM);
                c = 1'b1;
                r = PW'(-r);
            end
            else
                r = PW'(-q);
        end
        else if (q > LIM - QW'(1))
        begin
            r = PW'(LIM - QW'(1));
            c = 1'b1;
        end
        else
            r = PW'(q);
        return {c, r};
    endfunction

    ppil_ctx_t ce;
    logic [PW:0] fu, fv;
    logic [PW-1:0] px_n, py_n, pz_n;

    always_comb
    begin
        ce = cch[NSTEP];
        fu = fin(uch[NSTEP].q, ce.neg_u, ce.zero_u);
        fv = fin(wch[NSTEP].q, ce.neg_v, ce.zero_v);
        px_n = '0;
        py_n = '0;
        pz_n = '0;
        case (ce.axis)
            AXIS_X:
            begin
                py_n = fu[PW-1:0];
                pz_n = fv[PW-1:0];
            end
            AXIS_Y:
            begin
                px_n = fu[PW-1:0];
                pz_n = fv[PW-1:0];
            end
            default:
            begin
                px_n = fu[PW-1:0];
                py_n = fv[PW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= vch[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ce.found)
            begin
                dir_x     <= ce.dx;
                dir_y     <= ce.dy;
                dir_z     <= ce.dz;
                point_x   <= px_n;
                point_y   <= py_n;
                point_z   <= pz_n;
                found     <= 1'b1;
                zero_axis <= ce.axis;
                clipped   <= fu[PW] | fv[PW];
            end
            else
            begin
                dir_x     <= '0;
                dir_y     <= '0;
                dir_z     <= '0;
                point_x   <= '0;
                point_y   <= '0;
                point_z   <= '0;
                found     <= 1'b0;
                zero_axis <= AXIS_X;
                clipped   <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/ppil_cell.sv */
`default_nettype none
// One restoring division step for both quotients, with context carried along.
module ppil_cell
    import ppil_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      vin,
    input  ppil_ctx_t      cin,
    input  ppil_div_t      uin,
    input  ppil_div_t      win,
    output logic           vout,
    output ppil_ctx_t      cout,
    output ppil_div_t      uout,
    output ppil_div_t      wout
);
    localparam int BIT = QW - 1 - STEP;

    function automatic ppil_div_t stepf(ppil_div_t d, logic [PW-1:0] num,
                                        logic [PW-1:0] den);
        logic [QW:0]   r;
        logic [QW-1:0] dividend;
        ppil_div_t     o;
        dividend = {num, {FRAC{1'b0}}};
        r = {d.rem, dividend[BIT]};
        o = d;
        if (r >= {{(QW+1-PW){1'b0}}, den})
        begin
            r = r - {{(QW+1-PW){1'b0}}, den};
            o.q[BIT] = 1'b1;
        end
        o.rem = r[QW-1:0];
        return o;
    endfunction

    ppil_ctx_t ctx_reg;
    ppil_div_t u_reg;
    ppil_div_t w_reg;
    logic      v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= cin;
            u_reg   <= stepf(uin, cin.num_u, cin.den);
            w_reg   <= stepf(win, cin.num_v, cin.den);
        end
    end

    assign vout = v_reg;
    assign cout = ctx_reg;
    assign uout = u_reg;
    assign wout = w_reg;
endmodule
`default_nettype wire

/* rtl/ppil_checker.sv */
`default_nettype none
module ppil_checker
    import ppil_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic found,
    input wire logic clipped,
    input wire logic [1:0] zero_axis,
    input wire logic signed [DW-1:0] dir_x
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(found))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
    a_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> zero_axis != 2'd3)
        else $error("bad axis");
    a_nf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> !clipped && dir_x == '0 && zero_axis == AXIS_X)
        else $error("no-line result not cleared");
endmodule

bind plane_pair_intersection_line_unit ppil_checker u_ppil_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .found(found), .clipped(clipped),
    .zero_axis(zero_axis), .dir_x(dir_x)
);
`default_nettype wire
